### design/necir_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared types, window bounds and event codes for the NEC IR pulse decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int unsigned SAMPLES_W     = 32;
  localparam int unsigned SPU_W         = 10;
  localparam int unsigned RESET_SPU     = 24;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = 5;

  // Largest threshold is 42500 us at 1000 samples/us, which fits in 26 bits.
  localparam int unsigned THR_W = 26;

  // Timing windows, all open bounds in microseconds.
  localparam int unsigned NUM_WIN    = 6;
  localparam int unsigned WIN_LEAD   = 0;  // leader burst and repeat burst
  localparam int unsigned WIN_LSPACE = 1;  // leader space
  localparam int unsigned WIN_GAP    = 2;  // end gap
  localparam int unsigned WIN_RSPACE = 3;  // repeat space
  localparam int unsigned WIN_RMARK  = 4;  // repeat mark
  localparam int unsigned WIN_BIT    = 5;  // zero-bit space

  localparam int unsigned WIN_LO [NUM_WIN] = '{8700, 4250, 40500, 2100, 550, 400};
  localparam int unsigned WIN_HI [NUM_WIN] = '{9300, 4750, 42500, 2400, 620, 700};

  // Event codes.
  localparam logic [2:0] EV_LEADER_BURST = 3'd0;
  localparam logic [2:0] EV_LEADER_SPACE = 3'd1;
  localparam logic [2:0] EV_DATA_BYTE    = 3'd2;
  localparam logic [2:0] EV_END_GAP      = 3'd3;
  localparam logic [2:0] EV_REPEAT       = 3'd4;

  typedef struct packed {
    logic                 pulse_level;
    logic [SAMPLES_W-1:0] pulse_samples;
  } pulse_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [1:0] byte_index;
    logic [7:0] byte_value;
  } result_t;

  // A pulse after classification: its level and one hit flag per window.
  typedef struct packed {
    logic               level;
    logic [NUM_WIN-1:0] win;
  } class_t;

  // Scaled threshold: microseconds times samples per microsecond.
  function automatic logic [THR_W-1:0] scale_thr(input int unsigned us,
                                                 input logic [SPU_W-1:0] spu);
    logic [THR_W-1:0] prod;
    prod = THR_W'(us) * THR_W'(spu);
    return prod;
  endfunction

endpackage

### design/necir_queue.sv
// ----------------------------------------------------------------------------
// NEC IR small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module necir_queue import necir_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/necir_classify.sv
// ----------------------------------------------------------------------------
// NEC IR pulse classifier
// Holds scaled window thresholds and flags which windows a pulse falls in.
// ----------------------------------------------------------------------------
module necir_classify import necir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [SPU_W-1:0] cfg_samples_per_us,
  input  pulse_t           pulse,
  output class_t           cls
);

  logic [THR_W-1:0] thr_lo [NUM_WIN];
  logic [THR_W-1:0] thr_hi [NUM_WIN];
  logic [SPU_W-1:0] spu_eff;

  // A rate of zero is taken as one sample per microsecond.
  assign spu_eff = (cfg_samples_per_us == '0) ? SPU_W'(1) : cfg_samples_per_us;

  // Thresholds are scaled once when the rate is written, so the per-pulse
  // path is only a pair of compares per window.
  for (genvar i = 0; i < NUM_WIN; i++) begin : g_win
    always_ff @(posedge clk) begin
      if (rst) begin
        thr_lo[i] <= scale_thr(WIN_LO[i] + 1, SPU_W'(RESET_SPU));
        thr_hi[i] <= scale_thr(WIN_HI[i], SPU_W'(RESET_SPU));
      end else if (cfg_valid) begin
        thr_lo[i] <= scale_thr(WIN_LO[i] + 1, spu_eff);
        thr_hi[i] <= scale_thr(WIN_HI[i], spu_eff);
      end
    end

    assign cls.win[i] = (pulse.pulse_samples >= SAMPLES_W'(thr_lo[i])) &&
                        (pulse.pulse_samples <  SAMPLES_W'(thr_hi[i]));
  end

  assign cls.level = pulse.pulse_level;

endmodule

### design/necir_sequencer.sv
// ----------------------------------------------------------------------------
// NEC IR frame sequencer
// Walks the frame phases on classified pulses and forms the result beats.
// ----------------------------------------------------------------------------
module necir_sequencer import necir_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cls_valid,
  input  class_t  cls,
  output logic    cls_take,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LSPACE,
    PH_DMARK,
    PH_DSPACE,
    PH_STOP,
    PH_GAP,
    PH_RBURST,
    PH_RSPACE,
    PH_RMARK
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [BIT_CNT_W-1:0] bit_count;
  logic [BIT_CNT_W-1:0] bit_count_next;
  logic [7:0]           byte_shift;
  logic [7:0]           byte_shift_next;
  logic                 emit;
  result_t              ev;
  logic                 high;
  logic [7:0]           shifted;

  assign cls_take = cls_valid && !res_full;
  assign high     = cls.level;
  // A space outside the zero window reads as a one.
  assign shifted  = {!cls.win[WIN_BIT], byte_shift[7:1]};

  always_comb begin
    phase_next      = PH_IDLE;
    bit_count_next  = bit_count;
    byte_shift_next = byte_shift;
    emit            = 1'b0;
    ev              = '0;
    unique case (phase)
      PH_LSPACE: begin
        if (high && cls.win[WIN_LSPACE]) begin
          phase_next      = PH_DMARK;
          bit_count_next  = '0;
          byte_shift_next = 8'hFF;
          emit            = 1'b1;
          ev.event_kind   = EV_LEADER_SPACE;
        end
      end
      PH_DMARK: begin
        if (!high) begin
          phase_next = PH_DSPACE;
        end
      end
      PH_DSPACE: begin
        if (high) begin
          byte_shift_next = shifted;
          bit_count_next  = bit_count + 1'b1;
          phase_next      = (bit_count == '1) ? PH_STOP : PH_DMARK;
          if (bit_count[2:0] == 3'(BITS_PER_BYTE - 1)) begin
            emit          = 1'b1;
            ev.event_kind = EV_DATA_BYTE;
            ev.byte_index = bit_count[4:3];
            ev.byte_value = shifted;
          end
        end
      end
      PH_STOP: begin
        if (!high) begin
          phase_next = PH_GAP;
        end
      end
      PH_GAP: begin
        if (high && cls.win[WIN_GAP]) begin
          phase_next    = PH_RBURST;
          emit          = 1'b1;
          ev.event_kind = EV_END_GAP;
        end
      end
      PH_RBURST: begin
        if (!high && cls.win[WIN_LEAD]) begin
          phase_next = PH_RSPACE;
        end
      end
      PH_RSPACE: begin
        if (high && cls.win[WIN_RSPACE]) begin
          phase_next = PH_RMARK;
        end
      end
      PH_RMARK: begin
        if (!high && cls.win[WIN_RMARK]) begin
          emit          = 1'b1;
          ev.event_kind = EV_REPEAT;
        end
      end
      default: begin
        if (!high && cls.win[WIN_LEAD]) begin
          phase_next    = PH_LSPACE;
          emit          = 1'b1;
          ev.event_kind = EV_LEADER_BURST;
        end
      end
    endcase
  end

  assign res_push = cls_take && emit;
  assign res      = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      byte_shift <= 8'hFF;
    end else if (cls_take) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      byte_shift <= byte_shift_next;
    end
  end

endmodule

### design/nec_ir_pulse_decoder.sv
// ----------------------------------------------------------------------------
// NEC IR pulse decoder
// Decodes NEC infrared frames from measured pulses into leader, byte, gap
// and repeat events.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Beat contents
//   --------  -------------------  -------------------------------------------
//   pulse     push / full          pulse_t: level and length in samples
//   result    empty / pop          result_t: event kind, byte index and value
//   cfg       cfg_valid/cfg_ready  samples per microsecond (10 bits)
//
// One pulse beat is accepted per cycle while full is low. Each pulse is
// classified as it enters the classifier queue, and the sequencer pushes its
// result, if any, into the result queue, whose head stays on the result ports
// until popped. Reset clears both queues, returns the sequencer to idle and
// restores the rate of 24 samples per microsecond. When the result queue
// fills, the sequencer stops taking classified pulses, and full rises once
// the QUEUE_DEPTH-entry classifier queue has filled behind it.
//
// The front end scales the six timing windows by the configured rate when it
// is written, so that each pulse needs only a pair of 32-bit compares per
// window before it enters the classifier queue. A rate of zero acts as one.
// The back end is the frame sequencer; it consumes one classified pulse per
// cycle whenever the result queue has room and produces at most one result
// beat per pulse. Data bytes are assembled least significant bit first, and
// the inverse address and command bytes are passed on unchecked.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder import necir_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  pulse_t           pulse,
  output logic             empty,
  input  logic             pop,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SPU_W-1:0] cfg_samples_per_us
);

  class_t  cls_in;
  class_t  cls_out;
  logic    cls_empty;
  logic    cls_take;
  logic    res_full;
  logic    res_push;
  result_t res_in;

  // Always ready; the user must change the rate only while idle, unenforced.
  assign cfg_ready = 1'b1;

  necir_classify u_classify (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_samples_per_us (cfg_samples_per_us),
    .pulse              (pulse),
    .cls                (cls_in)
  );

  // Queue between the classifier and the sequencer.
  necir_queue #(
    .WIDTH ($bits(class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_in),
    .full  (full),
    .pop   (cls_take),
    .rdata (cls_out),
    .empty (cls_empty)
  );

  necir_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (!cls_empty),
    .cls       (cls_out),
    .cls_take  (cls_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue; its head drives the result ports directly.
  necir_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

### design/necir_checker.sv
// ----------------------------------------------------------------------------
// NEC IR decoder port checker
// Port-level assertions for the NEC IR pulse decoder, bound to the top level.
// ----------------------------------------------------------------------------
module necir_checker import necir_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for a pulse.
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("pulse queue full after reset");

  // Only data byte events carry an index and a value.
  a_plain_event: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.event_kind != EV_DATA_BYTE) |->
      (result.byte_index == '0 && result.byte_value == '0))
    else $error("non-byte event carries byte fields");

  // A waiting result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before it was taken");

endmodule

bind nec_ir_pulse_decoder necir_checker u_checker (.*);

### tb/tb_nec_ir_pulse_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NEC IR pulse decoder testbench
// Streams measured pulses into the decoder, mostly whole NEC frames with
// random payloads and the occasional broken pulse, at several sample rates.
// Every result beat is checked field by field against a frame decoder
// written here, or against a result written out by hand.
// ----------------------------------------------------------------------------
module tb_nec_ir_pulse_decoder import necir_pkg::*; ();

  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned PHASE_BEATS   = 125;
  localparam int unsigned MAX_REPORTS   = 10;
  // Cycles to let a pulse that gives no result drain through both queues.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 5000;

  // Where the frame decoder stands; the same walk as the sequencer in the block.
  typedef enum logic [3:0] {
    P_IDLE, P_LSPACE, P_DMARK, P_DSPACE, P_STOP, P_GAP, P_RBURST, P_RSPACE, P_RMARK
  } frame_phase_t;

  // One pulse beat of stimulus. Rows with typed set carry their expected result
  // written out by hand; all others take it from the frame decoder below.
  typedef struct packed {
    pulse_t  beat;
    logic    typed;
    logic    typed_has;
    result_t typed_ev;
  } stim_row_t;

  logic             clk                = 1'b0;
  logic             rst                = 1'b1;
  logic             push               = 1'b0;
  logic             full;
  pulse_t           pulse              = '0;
  logic             empty;
  logic             pop                = 1'b0;
  result_t          result;
  logic             cfg_valid          = 1'b0;
  logic             cfg_ready;
  logic [SPU_W-1:0] cfg_samples_per_us = '0;

  // Our own copy of the decoder state and of the rate register.
  logic [SPU_W-1:0] rate_spu    = SPU_W'(RESET_SPU);
  frame_phase_t     frame_phase = P_IDLE;
  logic [4:0]       bits_seen   = '0;
  logic [7:0]       shift_byte  = 8'hFF;

  // Events still owed by the block, oldest first.
  result_t     event_q[$];

  // While calm is set neither side inserts idle cycles.
  bit          calm        = 1'b0;
  int unsigned beats_in    = 0;
  int unsigned events_seen = 0;
  int unsigned frames_sent = 0;
  int unsigned failures    = 0;
  int unsigned reports     = 0;

  nec_ir_pulse_decoder dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .pulse              (pulse),
    .empty              (empty),
    .pop                (pop),
    .result             (result),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_samples_per_us (cfg_samples_per_us)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Frame decoder used for prediction
  // --------------------------------------------------------------------------

  // A rate of zero counts as one sample per microsecond.
  function automatic int unsigned rate_k();
    return (rate_spu == '0) ? 1 : int'(rate_spu);
  endfunction

  // True when the pulse length in whole microseconds lies strictly inside the
  // window. Done in 64 bits so that no product can wrap.
  function automatic bit in_win(input logic [31:0] s, input int unsigned w);
    longint unsigned k;
    k = 64'(rate_k());
    return (64'(s) >= (64'(WIN_LO[w]) + 1) * k) && (64'(s) < 64'(WIN_HI[w]) * k);
  endfunction

  // Advances the decoder by one pulse. Returns 1 when the pulse yields an event.
  function automatic bit decode_pulse(input pulse_t p, output result_t ev);
    frame_phase_t ph;
    logic [4:0]   n;
    bit           zero_bit;
    bit           has;
    ph          = frame_phase;
    frame_phase = P_IDLE;
    ev          = '0;
    has         = 1'b0;
    case (ph)
      P_LSPACE: begin
        if (p.pulse_level && in_win(p.pulse_samples, WIN_LSPACE)) begin
          frame_phase   = P_DMARK;
          bits_seen     = '0;
          shift_byte    = 8'hFF;
          ev.event_kind = EV_LEADER_SPACE;
          has           = 1'b1;
        end
      end
      P_DMARK: begin
        if (!p.pulse_level) frame_phase = P_DSPACE;
      end
      P_DSPACE: begin
        // A space is a zero only inside the short window; anything else is a one.
        if (p.pulse_level) begin
          zero_bit    = in_win(p.pulse_samples, WIN_BIT);
          n           = bits_seen;
          shift_byte  = {~zero_bit, shift_byte[7:1]};
          bits_seen   = n + 5'd1;
          frame_phase = (n == 5'd31) ? P_STOP : P_DMARK;
          if (n[2:0] == 3'd7) begin
            ev.event_kind = EV_DATA_BYTE;
            ev.byte_index = n[4:3];
            ev.byte_value = shift_byte;
            has           = 1'b1;
          end
        end
      end
      P_STOP: begin
        if (!p.pulse_level) frame_phase = P_GAP;
      end
      P_GAP: begin
        if (p.pulse_level && in_win(p.pulse_samples, WIN_GAP)) begin
          frame_phase   = P_RBURST;
          ev.event_kind = EV_END_GAP;
          has           = 1'b1;
        end
      end
      P_RBURST: begin
        if (!p.pulse_level && in_win(p.pulse_samples, WIN_LEAD)) frame_phase = P_RSPACE;
      end
      P_RSPACE: begin
        if (p.pulse_level && in_win(p.pulse_samples, WIN_RSPACE)) frame_phase = P_RMARK;
      end
      P_RMARK: begin
        if (!p.pulse_level && in_win(p.pulse_samples, WIN_RMARK)) begin
          ev.event_kind = EV_REPEAT;
          has           = 1'b1;
        end
      end
      default: begin
        // Idle: only a low pulse inside the leader window starts a frame.
        if (!p.pulse_level && in_win(p.pulse_samples, WIN_LEAD)) begin
          frame_phase   = P_LSPACE;
          ev.event_kind = EV_LEADER_BURST;
          has           = 1'b1;
        end
      end
    endcase
    return has;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_row_t pred_row(input logic lvl, input logic [31:0] s);
    stim_row_t r;
    r                    = '0;
    r.beat.pulse_level   = lvl;
    r.beat.pulse_samples = s;
    return r;
  endfunction

  // The kind is only looked at when has is set.
  function automatic stim_row_t fixed_row(input logic lvl, input logic [31:0] s,
                                          input logic has, input logic [2:0] kind);
    stim_row_t r;
    r                     = pred_row(lvl, s);
    r.typed               = 1'b1;
    r.typed_has           = has;
    r.typed_ev.event_kind = kind;
    return r;
  endfunction

  // Idle cycles before a beat: mostly none or a few, now and then a long pause.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample count for a window at the current rate. A hit lands on either edge
  // or anywhere between; a miss lands just outside, below, or anywhere at all.
  function automatic logic [31:0] win_len(input int unsigned w, input bit hit);
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    k  = rate_k();
    lo = (WIN_LO[w] + 1) * k;
    hi = WIN_HI[w] * k - 1;
    if (hit) begin
      case ($urandom_range(0, 3))
        0:       return lo;
        1:       return hi;
        default: return $urandom_range(hi, lo);
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return lo - 1;
      1:       return hi + 1;
      2:       return $urandom_range(lo - 1, 0);
      default: return $urandom;
    endcase
  endfunction

  // Mark lengths are never checked, so they are either typical or arbitrary.
  function automatic logic [31:0] mark_len();
    int unsigned k;
    k = rate_k();
    if ($urandom_range(0, 1) == 0) return 560 * k + $urandom_range(0, k - 1);
    return $urandom;
  endfunction

  // A windowed pulse falls outside its window about once in 25 pulses.
  function automatic bit in_spec();
    return $urandom_range(0, 24) != 0;
  endfunction

  // The line level is wrong about once in 400 pulses.
  function automatic bit level_slip();
    return $urandom_range(0, 399) == 0;
  endfunction

  // --------------------------------------------------------------------------
  // Pulse side
  // --------------------------------------------------------------------------

  // Offers one pulse beat, waits for the edge that takes it, then records what
  // the block now owes. push stays high when the next beat follows at once.
  task automatic send_row(input stim_row_t r);
    result_t     ev;
    bit          has;
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    pulse <= r.beat;
    do @(posedge clk); while (full);
    beats_in++;
    has = decode_pulse(r.beat, ev);
    if (r.typed) begin
      has = r.typed_has;
      ev  = r.typed_ev;
    end
    if (has) event_q.push_back(ev);
  endtask

  // One NEC frame with random payload, then a repeat code or a stray pulse.
  // Windowed pulses and levels are broken now and then, which sends the decoder
  // back to idle part way through.
  task automatic send_frame();
    int unsigned k;
    logic [31:0] space;
    frames_sent++;
    calm = ($urandom_range(0, 4) == 0);
    k    = rate_k();
    send_row(pred_row(level_slip(), win_len(WIN_LEAD, in_spec())));
    send_row(pred_row(!level_slip(), win_len(WIN_LSPACE, in_spec())));
    for (int b = 0; b < 32; b++) begin
      send_row(pred_row(level_slip(), mark_len()));
      case ($urandom_range(0, 3))
        0, 1:    space = win_len(WIN_BIT, 1'b1);
        2:       space = win_len(WIN_BIT, 1'b0);
        default: space = 1690 * k + $urandom_range(0, k - 1);
      endcase
      send_row(pred_row(!level_slip(), space));
    end
    send_row(pred_row(level_slip(), mark_len()));
    send_row(pred_row(!level_slip(), win_len(WIN_GAP, in_spec())));
    if ($urandom_range(0, 9) < 6) begin
      send_row(pred_row(level_slip(), win_len(WIN_LEAD, in_spec())));
      send_row(pred_row(!level_slip(), win_len(WIN_RSPACE, in_spec())));
      send_row(pred_row(level_slip(), win_len(WIN_RMARK, in_spec())));
    end else begin
      // Anything but a repeat burst here drops the decoder back to idle.
      send_row(pred_row(1'($urandom_range(0, 1)), $urandom));
    end
  endtask

  // The rate is only changed with the block idle: every owed event delivered,
  // then a few more cycles so that a pulse with no result has drained too.
  task automatic write_rate(input logic [SPU_W-1:0] v);
    push <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_samples_per_us <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_spu = v;
  endtask

  // --------------------------------------------------------------------------
  // Result side: pops with random stalls and checks each beat it takes.
  // --------------------------------------------------------------------------
  initial begin : result_side
    result_t     want;
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        events_seen++;
        if (event_q.size() == 0) begin
          failures++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("Unexpected event beat: kind %0d index %0d value 0x%02h",
                     result.event_kind, result.byte_index, result.byte_value);
          end
        end else begin
          want = event_q.pop_front();
          if (result.event_kind !== want.event_kind || result.byte_index !== want.byte_index ||
              result.byte_value !== want.byte_value) begin
            failures++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("Event mismatch at %0t: expected kind %0d index %0d value 0x%02h,",
                       $realtime, want.event_kind, want.byte_index, want.byte_value);
              $display("  got kind %0d index %0d value 0x%02h",
                       result.event_kind, result.byte_index, result.byte_value);
            end
          end
        end
      end
      // pop is written once per edge: held low through a stall, else high for
      // one beat after which a new stall is drawn.
      if (rst) begin
        pop <= 1'b0;
      end else if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        hold = gap_len();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t        directed_q[$];
    logic [SPU_W-1:0] rates[NUM_PHASES];
    int unsigned      phase_end;
    int unsigned      wait_cycles;

    // Phase 0 runs at the reset rate; the others cover the lowest and highest
    // legal rates, zero (taken as one), the widest register value and one
    // random rate.
    rates[0] = SPU_W'(RESET_SPU);
    rates[1] = SPU_W'(1);
    rates[2] = SPU_W'(1000);
    rates[3] = '0;
    rates[4] = '1;
    rates[5] = SPU_W'($urandom_range(2, 999));

    // Directed rows, all at the reset rate of 24 samples per microsecond.
    // Idle ignores high pulses and low pulses outside the leader window,
    // including both extremes of the length.
    directed_q.push_back(fixed_row(1'b1, 32'd0, 1'b0, EV_LEADER_BURST));
    directed_q.push_back(fixed_row(1'b1, 32'hFFFF_FFFF, 1'b0, EV_LEADER_BURST));
    directed_q.push_back(fixed_row(1'b0, 32'd0, 1'b0, EV_LEADER_BURST));
    directed_q.push_back(fixed_row(1'b0, 32'hFFFF_FFFF, 1'b0, EV_LEADER_BURST));
    // One sample short of 8701 us: still 8700 us, so not a leader.
    directed_q.push_back(fixed_row(1'b0, 32'd208823, 1'b0, EV_LEADER_BURST));
    // First sample count inside the leader window.
    directed_q.push_back(fixed_row(1'b0, 32'd208824, 1'b1, EV_LEADER_BURST));
    // A low pulse where the leader space belongs aborts the frame, and it is
    // not taken as a fresh leader even though its length would qualify.
    directed_q.push_back(fixed_row(1'b0, 32'd208824, 1'b0, EV_LEADER_BURST));
    // Last sample count inside the leader window.
    directed_q.push_back(fixed_row(1'b0, 32'd223199, 1'b1, EV_LEADER_BURST));
    // Exactly 4750 us is outside the open leader-space window.
    directed_q.push_back(fixed_row(1'b1, 32'd114000, 1'b0, EV_LEADER_BURST));
    // Exactly 9300 us is outside the open leader window.
    directed_q.push_back(fixed_row(1'b0, 32'd223200, 1'b0, EV_LEADER_BURST));
    directed_q.push_back(fixed_row(1'b0, 32'd215000, 1'b1, EV_LEADER_BURST));
    directed_q.push_back(fixed_row(1'b1, 32'd102024, 1'b1, EV_LEADER_SPACE));
    // Four bits on both edges of the zero window, with extreme mark lengths,
    // then a high pulse where a mark belongs, which aborts the frame.
    directed_q.push_back(pred_row(1'b0, 32'd0));
    directed_q.push_back(pred_row(1'b1, 32'd9624));
    directed_q.push_back(pred_row(1'b0, 32'hFFFF_FFFF));
    directed_q.push_back(pred_row(1'b1, 32'd16799));
    directed_q.push_back(pred_row(1'b0, 32'd5));
    directed_q.push_back(pred_row(1'b1, 32'd9623));
    directed_q.push_back(pred_row(1'b0, 32'd7));
    directed_q.push_back(pred_row(1'b1, 32'd16800));
    directed_q.push_back(pred_row(1'b1, 32'd0));
    directed_q.push_back(fixed_row(1'b1, 32'd102024, 1'b0, EV_LEADER_BURST));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) send_row(directed_q[i]);

    // Random phases: mostly whole frames, with stray pulses between them.
    phase_end = beats_in;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) write_rate(rates[ph]);
      phase_end += PHASE_BEATS;
      while (beats_in < phase_end) begin
        send_frame();
        if ($urandom_range(0, 3) == 0) begin
          send_row(pred_row(1'($urandom_range(0, 1)), $urandom));
        end
      end
    end

    // Drain: wait for every owed event, then a little longer so that a late
    // extra beat would still be seen.
    push <= 1'b0;
    wait_cycles = 0;
    while (event_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (event_q.size() != 0) begin
      failures += event_q.size();
      $display("%0d expected event beats never arrived", event_q.size());
    end

    $display("Covered %0d pulse beats (%0d frames) at six sample rates,",
             beats_in, frames_sent);
    $display("including zero and 1023; checked %0d event beats, %0d failures.",
             events_seen, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
